// ===== hw/rtl/multichannel_dac_ramp_sequencer_top_assert.svh =====
// assertion macros for the dac ramp sequencer checker
`ifndef MULTICHANNEL_DAC_RAMP_SEQUENCER_TOP_ASSERT_SVH
`define MULTICHANNEL_DAC_RAMP_SEQUENCER_TOP_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define DACRS_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dac ramp sequencer check failed");

// next-cycle implication, sampled on clk, off during reset
`define DACRS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dac ramp sequencer check failed");

`endif

// ===== hw/rtl/dacrs_pkg.sv =====
// shared types, constants and helpers for the dac ramp sequencer
`timescale 1ns / 1ps

package dacrs_pkg;

    localparam int CHANNELS   = 16;
    localparam int LEVEL_BITS = 12;

    localparam int CH_BITS    = 4;
    localparam int LVL_IN_BITS = 12;
    localparam int MUX_BITS   = 5;
    localparam int IDX_BITS   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    localparam logic [MUX_BITS-1:0]   MUX_IDLE    = MUX_BITS'(21);
    localparam logic [LEVEL_BITS-1:0] LEVEL_MAX   = {LEVEL_BITS{1'b1}};
    localparam logic [LEVEL_BITS-1:0] LEVEL_RESET = LEVEL_BITS'((1 << (LEVEL_BITS - 1)) - 1);
    localparam logic [LEVEL_BITS-1:0] LEVEL_MID   = LEVEL_BITS'(1 << (LEVEL_BITS - 1));

    typedef enum logic [2:0] {
        OP_SET_TARGET  = 3'd0,
        OP_RAMP_TICK   = 3'd1,
        OP_REFRESH_ALL = 3'd2,
        OP_ZERO_ALL    = 3'd3,
        OP_REFRESH_ONE = 3'd4
    } op_t;

    typedef struct packed {
        logic [2:0]             operation;
        logic [CH_BITS-1:0]     channel;
        logic [LVL_IN_BITS-1:0] level;
    } cmd_item_t;

    typedef struct packed {
        logic [MUX_BITS-1:0] mux_sel;
        logic [11:0]         dac_value;
        logic                dac_write;
        logic                ramp_active;
        logic                last;
    } res_item_t;

    // per-cycle commands broadcast to every cell
    typedef struct packed {
        logic set_target;
        logic tick;
        logic zero;
        logic shift;
    } cell_ctrl_t;

    // mux select for a channel: d + d/4 with d = CHANNELS-1-ch
    function automatic logic [MUX_BITS-1:0] mux_of(input logic [CH_BITS-1:0] ch);
        logic [MUX_BITS-1:0] d;
        d = MUX_BITS'(CHANNELS - 1) - {1'b0, ch};
        return d + (d >> 2);
    endfunction

    // clamp an incoming target to the level range
    function automatic logic [LEVEL_BITS-1:0] sat_level(input logic [LVL_IN_BITS-1:0] lvl);
        logic [16:0] w;
        w = 17'(lvl);
        if (w > 17'(LEVEL_MAX)) begin
            return LEVEL_MAX;
        end
        return LEVEL_BITS'(w);
    endfunction

endpackage

// ===== hw/rtl/multichannel_dac_ramp_sequencer_top.sv =====
// top level of the multichannel dac ramp sequencer
`timescale 1ns / 1ps

// Commands arrive on cmd (cmd_valid / cmd_stall), results leave on res
// (res_valid / res_stall); a transfer happens when valid is high and stall low.
// Levels live in a ring of channel cells; a refresh rotates the ring one
// place per result so channel order comes out of the head cell, and after
// all channels the ring is back where it started.
// Set target: no result, next command taken right away.
// Ramp tick: all cells step in parallel at the transfer, then one result (deselect).
// Refresh all / zero all: 16 channel writes then the deselect, one result per
// cycle while res is not stalled, so 17 results; the block is then idle again
// and takes the next command.
// Refresh one: one write plus the deselect (deselect only for a bad channel).
// The rate is set by the single result register: one result per cycle, and
// cmd_stall stays high until the last result of a command is registered.
// A stall on res holds the result register and, outside idle, freezes the ring and sequencer.
// Reset puts every actual and target level at 2047 and clears res_valid.

module multichannel_dac_ramp_sequencer_top
    import dacrs_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cmd_valid,
    output logic      cmd_stall,
    input  cmd_item_t cmd,
    output logic      res_valid,
    input  logic      res_stall,
    output res_item_t res
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_REFRESH,
        ST_ONE,
        ST_DESEL
    } state_t;

    localparam logic [IDX_BITS-1:0] LAST_IDX = IDX_BITS'(CHANNELS - 1);

    state_t                state_reg, state_next;
    logic [IDX_BITS-1:0]   idx_reg, idx_next;
    logic [CH_BITS-1:0]    ch_reg, ch_next;
    logic                  ramp_reg, ramp_next;
    logic                  res_valid_reg, res_valid_next;
    res_item_t             res_reg, res_next;

    cell_ctrl_t            ctrl;
    logic                  cmd_fire;
    logic                  res_free;
    logic                  ch_ok;
    logic                  moved_any;
    logic [LEVEL_BITS-1:0] new_target;
    logic [LEVEL_BITS-1:0] actual [CHANNELS];
    logic [LEVEL_BITS-1:0] target [CHANNELS];
    logic [CHANNELS-1:0]   moved;
    logic [CHANNELS-1:0]   sel;

    assign cmd_stall  = (state_reg != ST_IDLE);
    assign cmd_fire   = cmd_valid && !cmd_stall;
    assign res_free   = !res_valid_reg || !res_stall;
    assign ch_ok      = ({1'b0, cmd.channel} < (CH_BITS + 1)'(CHANNELS));
    assign moved_any  = |moved;
    assign new_target = sat_level(cmd.level);

    // ring of channel cells, each shifting from its upper neighbor
    for (genvar i = 0; i < CHANNELS; i++) begin : g_cell
        assign sel[i] = (cmd.channel[IDX_BITS-1:0] == IDX_BITS'(i));

        dacrs_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (ctrl),
            .sel        (sel[i]),
            .new_target (new_target),
            .nbr_actual (actual[(i + 1) % CHANNELS]),
            .nbr_target (target[(i + 1) % CHANNELS]),
            .actual     (actual[i]),
            .target     (target[i]),
            .moved      (moved[i])
        );
    end

    // sequencer next state and result assembly
    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        ch_next        = ch_reg;
        ramp_next      = ramp_reg;
        res_valid_next = res_valid_reg && res_stall;
        res_next       = res_reg;
        ctrl           = '0;

        unique case (state_reg)
            ST_IDLE: begin
                if (cmd_fire) begin
                    unique case (cmd.operation)
                        OP_SET_TARGET: begin
                            ctrl.set_target = ch_ok;
                        end
                        OP_RAMP_TICK: begin
                            ctrl.tick  = 1'b1;
                            ramp_next  = moved_any;
                            state_next = ST_DESEL;
                        end
                        OP_REFRESH_ALL: begin
                            idx_next   = '0;
                            state_next = ST_REFRESH;
                        end
                        OP_ZERO_ALL: begin
                            ctrl.zero  = 1'b1;
                            idx_next   = '0;
                            state_next = ST_REFRESH;
                        end
                        OP_REFRESH_ONE: begin
                            ch_next    = cmd.channel;
                            state_next = ch_ok ? ST_ONE : ST_DESEL;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_REFRESH: begin
                if (res_free) begin
                    res_next.mux_sel     = mux_of(CH_BITS'(idx_reg));
                    res_next.dac_value   = 12'(actual[0]);
                    res_next.dac_write   = 1'b1;
                    res_next.ramp_active = 1'b0;
                    res_next.last        = 1'b0;
                    res_valid_next       = 1'b1;
                    ctrl.shift           = 1'b1;
                    idx_next             = idx_reg + IDX_BITS'(1);
                    if (idx_reg == LAST_IDX) begin
                        state_next = ST_DESEL;
                    end
                end
            end
            ST_ONE: begin
                if (res_free) begin
                    res_next.mux_sel     = mux_of(ch_reg);
                    res_next.dac_value   = 12'(actual[ch_reg[IDX_BITS-1:0]]);
                    res_next.dac_write   = 1'b1;
                    res_next.ramp_active = 1'b0;
                    res_next.last        = 1'b0;
                    res_valid_next       = 1'b1;
                    state_next           = ST_DESEL;
                end
            end
            ST_DESEL: begin
                if (res_free) begin
                    res_next.mux_sel     = MUX_IDLE;
                    res_next.dac_value   = '0;
                    res_next.dac_write   = 1'b0;
                    res_next.ramp_active = ramp_reg;
                    res_next.last        = 1'b1;
                    res_valid_next       = 1'b1;
                    ramp_next            = 1'b0;
                    state_next           = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= ST_IDLE;
            idx_reg       <= '0;
            ch_reg        <= '0;
            ramp_reg      <= 1'b0;
            res_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            ch_reg        <= ch_next;
            ramp_reg      <= ramp_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

// ===== hw/rtl/dacrs_cell.sv =====
// one channel cell: actual and target level, ramp step and ring shift
`timescale 1ns / 1ps

module dacrs_cell
    import dacrs_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  cell_ctrl_t            ctrl,
    input  logic                  sel,
    input  logic [LEVEL_BITS-1:0] new_target,
    input  logic [LEVEL_BITS-1:0] nbr_actual,
    input  logic [LEVEL_BITS-1:0] nbr_target,
    output logic [LEVEL_BITS-1:0] actual,
    output logic [LEVEL_BITS-1:0] target,
    output logic                  moved
);

    logic [LEVEL_BITS-1:0] actual_reg, actual_next;
    logic [LEVEL_BITS-1:0] target_reg, target_next;

    // next levels: shift from neighbor, zero-all to mid-scale, ramp step or target write
    always_comb
    begin
        actual_next = actual_reg;
        target_next = target_reg;
        if (ctrl.shift) begin
            actual_next = nbr_actual;
            target_next = nbr_target;
        end else if (ctrl.zero) begin
            actual_next = LEVEL_MID;
        end else if (ctrl.tick) begin
            if (actual_reg > target_reg) begin
                actual_next = actual_reg - LEVEL_BITS'(1);
            end else if (actual_reg < target_reg) begin
                actual_next = actual_reg + LEVEL_BITS'(1);
            end
        end else if (ctrl.set_target && sel) begin
            target_next = new_target;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            actual_reg <= LEVEL_RESET;
            target_reg <= LEVEL_RESET;
        end else begin
            actual_reg <= actual_next;
            target_reg <= target_next;
        end
    end

    assign actual = actual_reg;
    assign target = target_reg;
    assign moved  = (actual_reg != target_reg);

endmodule

// ===== hw/rtl/dacrs_checker.sv =====
// port-level checker for the dac ramp sequencer, bound to the top level
`timescale 1ns / 1ps

`include "multichannel_dac_ramp_sequencer_top_assert.svh"

module dacrs_checker
    import dacrs_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      cmd_valid,
    input logic      cmd_stall,
    input cmd_item_t cmd,
    input logic      res_valid,
    input logic      res_stall,
    input res_item_t res
);

    logic cmd_xfer;
    logic busy_op;

    assign cmd_xfer = cmd_valid && !cmd_stall;
    assign busy_op  = (cmd.operation == OP_RAMP_TICK) || (cmd.operation == OP_REFRESH_ALL)
                   || (cmd.operation == OP_ZERO_ALL) || (cmd.operation == OP_REFRESH_ONE);

    // a stalled result holds
    `DACRS_ASSERT_NEXT(a_res_hold, res_valid && res_stall, res_valid && $stable(res))

    // any command that produces results blocks the next command
    `DACRS_ASSERT_NEXT(a_busy_after_cmd, cmd_xfer && busy_op, cmd_stall)

    // the final result of a command is always the deselect
    `DACRS_ASSERT_IMPLY(a_last_is_desel, res_valid && res.last,
        (res.mux_sel == MUX_IDLE) && !res.dac_write && (res.dac_value == '0))

    // a converter write never carries the ramp flag or the last mark
    `DACRS_ASSERT_IMPLY(a_write_clean, res_valid && res.dac_write,
        !res.ramp_active && !res.last && (res.mux_sel != MUX_IDLE))

endmodule

bind multichannel_dac_ramp_sequencer_top dacrs_checker u_dacrs_checker (.*);

// ===== tb/sv/tb.sv =====
// self-checking testbench for the dac ramp sequencer with a level-table predictor
`timescale 1ns / 1ps

module tb;
    import dacrs_pkg::*;

    localparam int         IDLE_LIMIT    = 1000;
    localparam int         SETTLE_CYCLES = 24;
    localparam int         RANDOM_ITEMS  = 300;
    localparam int         MAX_WAIT      = 6;
    localparam int         QUIET_EVERY   = 40;
    localparam int         DRAIN_AT      = 150;
    localparam logic [2:0] OP_UNDEF_LO   = 3'd5;
    localparam logic [2:0] OP_UNDEF_MID  = 3'd6;
    localparam logic [2:0] OP_UNDEF_HI   = 3'd7;

    // level table mirror and queue of converter writes still to come
    class level_sequence_board;
        logic [LEVEL_BITS-1:0] actual_lvl [CHANNELS];
        logic [LEVEL_BITS-1:0] target_lvl [CHANNELS];
        res_item_t             expected_writes [$];
        int                    errors;

        function new();
            for (int i = 0; i < CHANNELS; i++)
            begin
                actual_lvl[i] = LEVEL_RESET;
                target_lvl[i] = LEVEL_RESET;
            end
            errors = 0;
        endfunction

        // mux select: distance from the top channel plus one skip per group of four
        function logic [MUX_BITS-1:0] channel_mux(int ch);
            int offset;
            offset = CHANNELS - 1 - ch;
            return MUX_BITS'(offset + offset / 4);
        endfunction

        function void expect_write(logic [MUX_BITS-1:0] mux, logic [11:0] value,
                                   logic wr, logic ramp, logic is_last);
            res_item_t r;
            r.mux_sel     = mux;
            r.dac_value   = value;
            r.dac_write   = wr;
            r.ramp_active = ramp;
            r.last        = is_last;
            expected_writes.push_back(r);
        endfunction

        function void expect_refresh_all();
            for (int ch = 0; ch < CHANNELS; ch++)
            begin
                expect_write(channel_mux(ch), 12'(actual_lvl[ch]), 1'b1, 1'b0, 1'b0);
            end
            expect_write(MUX_IDLE, '0, 1'b0, 1'b0, 1'b1);
        endfunction

        // update the table for one accepted command and queue its writes
        function void note_command(cmd_item_t c);
            logic moved;
            moved = 1'b0;
            case (c.operation)
                OP_SET_TARGET:
                begin
                    if (int'(c.channel) < CHANNELS)
                    begin
                        target_lvl[c.channel] = (c.level > LEVEL_MAX) ? LEVEL_MAX
                                                                      : LEVEL_BITS'(c.level);
                    end
                end
                OP_RAMP_TICK:
                begin
                    for (int i = 0; i < CHANNELS; i++)
                    begin
                        if (actual_lvl[i] != target_lvl[i])
                        begin
                            if (actual_lvl[i] > target_lvl[i])
                                actual_lvl[i] = actual_lvl[i] - LEVEL_BITS'(1);
                            else
                                actual_lvl[i] = actual_lvl[i] + LEVEL_BITS'(1);
                            moved = 1'b1;
                        end
                    end
                    expect_write(MUX_IDLE, '0, 1'b0, moved, 1'b1);
                end
                OP_REFRESH_ALL:
                begin
                    expect_refresh_all();
                end
                OP_ZERO_ALL:
                begin
                    for (int i = 0; i < CHANNELS; i++)
                        actual_lvl[i] = LEVEL_MID;
                    expect_refresh_all();
                end
                OP_REFRESH_ONE:
                begin
                    if (int'(c.channel) < CHANNELS)
                    begin
                        expect_write(channel_mux(int'(c.channel)), 12'(actual_lvl[c.channel]),
                                     1'b1, 1'b0, 1'b0);
                    end
                    expect_write(MUX_IDLE, '0, 1'b0, 1'b0, 1'b1);
                end
                default:
                begin
                end
            endcase
        endfunction

        // compare one result transfer with the oldest queued write
        function void check_write(res_item_t got);
            res_item_t want;
            if (expected_writes.size() == 0)
            begin
                $error("unexpected result: mux_sel %0d dac_value %0d last %0d",
                       got.mux_sel, got.dac_value, got.last);
                errors++;
                return;
            end
            want = expected_writes.pop_front();
            if (got.mux_sel !== want.mux_sel)
            begin
                $error("mux_sel expected %0d got %0d", want.mux_sel, got.mux_sel);
                errors++;
            end
            if (got.dac_value !== want.dac_value)
            begin
                $error("dac_value expected %0d got %0d", want.dac_value, got.dac_value);
                errors++;
            end
            if (got.dac_write !== want.dac_write)
            begin
                $error("dac_write expected %0d got %0d", want.dac_write, got.dac_write);
                errors++;
            end
            if (got.ramp_active !== want.ramp_active)
            begin
                $error("ramp_active expected %0d got %0d", want.ramp_active, got.ramp_active);
                errors++;
            end
            if (got.last !== want.last)
            begin
                $error("last expected %0d got %0d", want.last, got.last);
                errors++;
            end
        endfunction
    endclass

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      cmd_valid = 1'b0;
    logic      cmd_stall;
    cmd_item_t cmd       = '0;
    logic      res_valid;
    logic      res_stall = 1'b0;
    res_item_t res;

    level_sequence_board board;
    bit                  tx_quiet    = 1'b0;
    bit                  rx_quiet    = 1'b0;
    int                  stall_left  = 0;
    int                  idle_cycles = 0;

    multichannel_dac_ramp_sequencer_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res)
    );

    // clock
    always #1 clk = ~clk;

    function automatic int wait_draw(bit quiet);
        return quiet ? 0 : $urandom_range(0, MAX_WAIT);
    endfunction

    function automatic cmd_item_t make_cmd(logic [2:0] op, int ch, int lvl);
        cmd_item_t c;
        c.operation = op;
        c.channel   = CH_BITS'(ch);
        c.level     = LVL_IN_BITS'(lvl);
        return c;
    endfunction

    // one command transfer after a random gap
    task automatic send_cmd(input cmd_item_t c);
        int gap;
        gap = wait_draw(tx_quiet);
        if (gap > 0)
        begin
            cmd_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_valid <= 1'b1;
        cmd       <= c;
        do @(posedge clk); while (cmd_stall);
        board.note_command(c);
    endtask

    // hold off commands until every queued write has come out
    task automatic drain_results();
        cmd_valid <= 1'b0;
        while (board.expected_writes.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // result side: check each transfer, then stall for a random count
    always @(posedge clk)
    begin
        if (rst_n && res_valid && !res_stall)
        begin
            board.check_write(res);
            stall_left = wait_draw(rx_quiet);
        end
        else if (stall_left > 0)
        begin
            stall_left--;
        end
        res_stall <= (stall_left != 0);
    end

    // watchdog on cycles with no transfer on either side
    always @(posedge clk)
    begin
        if ((cmd_valid && !cmd_stall) || (res_valid && !res_stall))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("tb failed");
            $finish;
        end
    end

    // stimulus
    initial
    begin
        cmd_item_t c;
        int        sent;
        int        pick;
        bit        drained;

        board   = new();
        sent    = 0;
        drained = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset levels, idle tick, extremes of target and channel
        send_cmd(make_cmd(OP_REFRESH_ALL, 0, 0));
        send_cmd(make_cmd(OP_RAMP_TICK, 0, 0));
        send_cmd(make_cmd(OP_SET_TARGET, 0, 0));
        send_cmd(make_cmd(OP_SET_TARGET, 15, 4095));
        send_cmd(make_cmd(OP_SET_TARGET, 7, 2048));
        send_cmd(make_cmd(OP_RAMP_TICK, 0, 0));
        send_cmd(make_cmd(OP_REFRESH_ONE, 0, 0));
        send_cmd(make_cmd(OP_REFRESH_ONE, 15, 4095));
        send_cmd(make_cmd(OP_ZERO_ALL, 3, 0));
        send_cmd(make_cmd(OP_REFRESH_ONE, 7, 0));
        // undefined operations are ignored
        send_cmd(make_cmd(OP_UNDEF_LO, 5, 4095));
        send_cmd(make_cmd(OP_UNDEF_MID, 10, 0));
        send_cmd(make_cmd(OP_UNDEF_HI, 15, 4095));
        // alternating bit patterns
        send_cmd(make_cmd(OP_SET_TARGET, 5, 12'hAAA));
        send_cmd(make_cmd(OP_SET_TARGET, 10, 12'h555));
        send_cmd(make_cmd(OP_RAMP_TICK, 0, 0));
        send_cmd(make_cmd(OP_RAMP_TICK, 0, 0));
        send_cmd(make_cmd(OP_REFRESH_ALL, 0, 0));
        send_cmd(make_cmd(OP_REFRESH_ONE, 5, 0));

        // random mix, targets mostly near mid-scale so ramps settle
        while (sent < RANDOM_ITEMS)
        begin
            if (sent % QUIET_EVERY == 0)
            begin
                tx_quiet = ($urandom_range(0, 3) == 0);
                rx_quiet = ($urandom_range(0, 3) == 0);
            end
            if (!drained && sent == DRAIN_AT)
            begin
                drain_results();
                drained = 1'b1;
            end
            pick      = $urandom_range(0, 99);
            c.channel = CH_BITS'($urandom_range(0, CHANNELS - 1));
            if ($urandom_range(0, 2) != 0)
                c.level = LVL_IN_BITS'(int'(LEVEL_MID) + $urandom_range(0, 15) - 8);
            else
                c.level = LVL_IN_BITS'($urandom_range(0, 4095));
            if (pick < 30)
                c.operation = OP_SET_TARGET;
            else if (pick < 65)
                c.operation = OP_RAMP_TICK;
            else if (pick < 80)
                c.operation = OP_REFRESH_ONE;
            else if (pick < 90)
                c.operation = OP_REFRESH_ALL;
            else if (pick < 94)
                c.operation = OP_ZERO_ALL;
            else
                c.operation = 3'($urandom_range(int'(OP_UNDEF_LO), int'(OP_UNDEF_HI)));
            send_cmd(c);
            if (c.operation < OP_UNDEF_LO)
                sent++;
        end

        // wrap up
        drain_results();
        if (board.errors == 0 && board.expected_writes.size() == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/dacrs_pkg.sv
hw/rtl/dacrs_cell.sv
hw/rtl/multichannel_dac_ramp_sequencer_top.sv
hw/rtl/dacrs_checker.sv
tb/sv/tb.sv
